@@ design/crcd_pkg.sv @@
// Shared constants, types and functions of the command frame deframer.
package crcd_pkg;

  // Longest frame: set parameter. Checking is eager, so the buffer never holds more.
  localparam int unsigned FRAME_MAX = 18;
  localparam int unsigned FILL_W    = $clog2(FRAME_MAX + 1);
  localparam int unsigned HDR_BYTES = 4;

  localparam logic [7:0] MAGIC_LO    = 8'hB2;
  localparam logic [7:0] MAGIC_HI    = 8'hA1;
  localparam logic [7:0] VERSION     = 8'h01;
  localparam logic [7:0] TYPE_TARE   = 8'h10;
  localparam logic [7:0] TYPE_CAL    = 8'h11;
  localparam logic [7:0] TYPE_GETCFG = 8'h12;
  localparam logic [7:0] TYPE_SETPRM = 8'h13;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [FILL_W-1:0] LEN_NONE   = FILL_W'(0);
  localparam logic [FILL_W-1:0] LEN_SHORT  = FILL_W'(8);
  localparam logic [FILL_W-1:0] LEN_CAL    = FILL_W'(10);
  localparam logic [FILL_W-1:0] LEN_SETPRM = FILL_W'(18);

  typedef enum logic [1:0] {
    KIND_TARE,
    KIND_CAL,
    KIND_GETCFG,
    KIND_SETPRM
  } kind_e;

  // What the arriving byte does to the buffer.
  typedef enum logic [1:0] {
    ACT_STORE,
    ACT_DROP1,
    ACT_DROP2,
    ACT_FLUSH
  } act_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] float_value;
    logic [7:0]  setting_id;
    logic        param_known;
    logic [31:0] int_value;
  } result_t;

  // One byte of CRC-16/CCITT, MSB first.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [FILL_W-1:0] frame_len(logic [7:0] kind_byte);
    logic [FILL_W-1:0] len;
    case (kind_byte)
      TYPE_TARE:   len = LEN_SHORT;
      TYPE_CAL:    len = LEN_CAL;
      TYPE_GETCFG: len = LEN_SHORT;
      TYPE_SETPRM: len = LEN_SETPRM;
      default:     len = LEN_NONE;
    endcase
    return len;
  endfunction

  function automatic logic id_known(logic [7:0] id);
    return id inside {[8'd1:8'd4], [8'd7:8'd11]};
  endfunction

endpackage

@@ design/crcd_ifs.sv @@
// Valid/ready channel interfaces for received bytes and decoded commands.
interface crcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command_kind;
  logic [31:0] float_value;
  logic [7:0]  setting_id;
  logic        param_known;
  logic [31:0] int_value;

  modport source (output valid, output command_kind, output float_value, output setting_id,
                  output param_known, output int_value, input ready);
  modport sink   (input valid, input command_kind, input float_value, input setting_id,
                  input param_known, input int_value, output ready);
endinterface

@@ design/crc_checked_command_deframer.sv @@
// Top level of the CRC-checked command frame deframer.
//
//   channel  dir  payload                                        handshake
//   rx_i     in   rx_byte[7:0]                                   valid/ready
//   cmd_o    out  command_kind, float_value, setting_id,         valid/ready
//                 param_known, int_value
//
// Every byte request is handled in the cycle it is accepted: the header checks,
// the CRC update and the trailer compare all sit between the buffer registers,
// so one byte is taken per clock while rx_i.ready is high, each CRC advancing by one byte-wide step.
// A decoded command with a good CRC is registered in the result buffer when its last byte is accepted.
// Reset empties the buffer and loads the CRC with FFFF; no clearing pass is needed.
// A two-entry result buffer lets bytes keep flowing while one command waits;
// rx_i.ready drops only when both entries are held by a stalled consumer.
module crc_checked_command_deframer import crcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  crcd_in_if.sink    rx_i,
  crcd_out_if.source cmd_o
);

  // Buffer of received bytes. Entries 0..3 hold the header and shift when a
  // bad header is dropped; the rest are written in place.
  logic [7:0]        store_q [FRAME_MAX];
  logic [7:0]        store_d [FRAME_MAX];
  logic [FILL_W-1:0] fill_q, fill_d;

  // The running CRC of the frame body, plus two spare CRCs that start at
  // buffer positions 1 and 2. When a bad header drops one or two bytes, the
  // spares already hold the CRC of what remains, so no recomputation is needed.
  logic [15:0] crc_a_q, crc_a_d;
  logic [15:0] crc_b_q, crc_b_d;
  logic [15:0] crc_c_q, crc_c_d;

  logic [7:0]        rx_byte;
  logic              accept;
  logic              buf_full;
  logic [7:0]        hdr_w [HDR_BYTES];
  logic [FILL_W-1:0] len_w;
  logic              at_hdr;
  logic              magic_ok, version_ok;
  logic              in_body;
  logic              complete;
  logic [7:0]        trailer_lo;
  logic              crc_ok;
  logic [15:0]       step_a, step_b, step_c, step_d;
  act_e              act;
  result_t           res;
  logic              res_push;

  assign rx_byte    = rx_i.rx_byte;
  assign rx_i.ready = !buf_full;
  assign accept     = rx_i.valid && !buf_full;

  // Header as it stands once the arriving byte is written.
  always_comb begin
    for (int k = 0; k < HDR_BYTES; k++) begin
      hdr_w[k] = (fill_q == FILL_W'(k)) ? rx_byte : store_q[k];
    end
  end

  assign len_w      = frame_len(hdr_w[3]);
  assign at_hdr     = (fill_q == FILL_W'(HDR_BYTES - 1));
  assign magic_ok   = (hdr_w[0] == MAGIC_LO) && (hdr_w[1] == MAGIC_HI);
  assign version_ok = (hdr_w[2] == VERSION);

  // A byte feeds the body CRC while it lies in the header or before the trailer.
  assign in_body  = (fill_q < FILL_W'(HDR_BYTES)) ||
                    (({1'b0, fill_q} + (FILL_W + 1)'(2)) < {1'b0, len_w});
  assign complete = (fill_q >= FILL_W'(HDR_BYTES)) && ((fill_q + FILL_W'(1)) == len_w);

  // Low byte of the trailer is already buffered; the high byte is arriving now.
  always_comb begin
    case (len_w)
      LEN_CAL:    trailer_lo = store_q[8];
      LEN_SETPRM: trailer_lo = store_q[16];
      default:    trailer_lo = store_q[6];
    endcase
  end

  assign crc_ok = ({rx_byte, trailer_lo} == crc_a_q);

  assign step_a = crc_byte(crc_a_q, rx_byte);
  assign step_b = crc_byte((fill_q <= FILL_W'(1)) ? CRC_INIT : crc_b_q, rx_byte);
  assign step_c = crc_byte((fill_q <= FILL_W'(2)) ? CRC_INIT : crc_c_q, rx_byte);
  assign step_d = crc_byte(CRC_INIT, rx_byte);

  // Header checks only matter when the fourth byte arrives; a header that
  // passes then stays good until the frame completes.
  always_comb begin
    if (at_hdr && !magic_ok) begin
      act = ACT_DROP1;
    end else if (at_hdr && (!version_ok || (len_w == LEN_NONE))) begin
      act = ACT_DROP2;
    end else if (complete) begin
      act = ACT_FLUSH;
    end else begin
      act = ACT_STORE;
    end
  end

  always_comb begin
    fill_d  = fill_q;
    crc_a_d = crc_a_q;
    crc_b_d = crc_b_q;
    crc_c_d = crc_c_q;
    for (int k = 0; k < FRAME_MAX; k++) begin
      store_d[k] = store_q[k];
    end
    if (accept) begin
      case (act)
        ACT_DROP1: begin
          // Slide the header down by one byte.
          fill_d     = FILL_W'(HDR_BYTES - 1);
          store_d[0] = hdr_w[1];
          store_d[1] = hdr_w[2];
          store_d[2] = hdr_w[3];
          crc_a_d    = step_b;
          crc_b_d    = step_c;
          crc_c_d    = step_d;
        end
        ACT_DROP2: begin
          // Slide the header down by two bytes.
          fill_d     = FILL_W'(HDR_BYTES - 2);
          store_d[0] = hdr_w[2];
          store_d[1] = hdr_w[3];
          crc_a_d    = step_c;
          crc_b_d    = step_d;
          crc_c_d    = step_d;
        end
        ACT_FLUSH: begin
          // Whole frame leaves the buffer, good or bad.
          fill_d  = '0;
          crc_a_d = CRC_INIT;
        end
        default: begin
          fill_d  = fill_q + FILL_W'(1);
          crc_a_d = in_body ? step_a : crc_a_q;
          crc_b_d = step_b;
          crc_c_d = step_c;
          for (int k = 0; k < FRAME_MAX; k++) begin
            if (fill_q == FILL_W'(k)) begin
              store_d[k] = rx_byte;
            end
          end
        end
      endcase
    end
  end

  // Decode the completed frame; fields not used by a kind read as zero.
  always_comb begin
    res             = '0;
    res.kind        = kind_e'(hdr_w[3][1:0]);
    if (hdr_w[3] == TYPE_CAL) begin
      res.float_value = {store_q[7], store_q[6], store_q[5], store_q[4]};
    end else if (hdr_w[3] == TYPE_SETPRM) begin
      res.float_value = {store_q[11], store_q[10], store_q[9], store_q[8]};
      res.setting_id  = store_q[4];
      res.param_known = id_known(store_q[4]);
      res.int_value   = {store_q[15], store_q[14], store_q[13], store_q[12]};
    end
  end

  assign res_push = accept && (act == ACT_FLUSH) && crc_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      crc_a_q <= CRC_INIT;
      crc_b_q <= CRC_INIT;
      crc_c_q <= CRC_INIT;
    end else begin
      fill_q  <= fill_d;
      crc_a_q <= crc_a_d;
      crc_b_q <= crc_b_d;
      crc_c_q <= crc_c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < FRAME_MAX; k++) begin
      store_q[k] <= store_d[k];
    end
  end

  crcd_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res),
    .full_o      (buf_full),
    .res_o       (cmd_o)
  );

endmodule

@@ design/crcd_result_buf.sv @@
// Two-entry result buffer: output register plus a skid register.
module crcd_result_buf import crcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  result_t     push_data_i,
  output logic        full_o,
  crcd_out_if.source  res_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop    = out_valid_q && res_o.ready;
  assign full_o = skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.command_kind = out_q.kind;
  assign res_o.float_value  = out_q.float_value;
  assign res_o.setting_id   = out_q.setting_id;
  assign res_o.param_known  = out_q.param_known;
  assign res_o.int_value    = out_q.int_value;

endmodule
